/* design/fsdrp_pkg.sv */
package fsdrp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int DEC_BASE    = 10;
  localparam int NUM_STORED  = 3;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_WS,
    PH_DISCARD
  } phase_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // sign-extend or cut a value to the output width
  function automatic logic signed [OUT_WIDTH-1:0] to_out(input value_t v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = signed'(v);
    return OUT_WIDTH'(s);
  endfunction

endpackage

/* design/four_signed_decimal_record_parser.sv */
// Parses a byte stream of records, one item per byte (or an end-of-input mark), at a
// sustained rate of one item per clock. Each record drops skip_bytes leading bytes,
// then reads four decimal numbers with optional minus sign, separated by whitespace,
// and discards the rest of the line. One result item comes out per record, after the byte
// that closes it has passed the input register, and is held in the result register. The
// per-byte work is a multiply-by-ten add on a 32-bit accumulator between those two
// registers. Input stalls only while a result waits at the output and the byte held in
// the input register is blocked behind it. record_ok low means the record was malformed
// or ended early; its four values are then zero.
module four_signed_decimal_record_parser
  import fsdrp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_input,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  skip_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] x_low,
  output logic signed [OUT_WIDTH-1:0] y_low,
  output logic signed [OUT_WIDTH-1:0] x_high,
  output logic signed [OUT_WIDTH-1:0] y_high,
  output logic                        record_ok,
  output logic                        closed_by_end
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eof;
  logic       advance;

  logic [7:0] skip_count;
  phase_t     phase, phase_next;
  logic [7:0] skip_left, skip_left_next;
  logic [1:0] field_index, field_index_next;
  logic       negative_flag, negative_flag_next;
  value_t     accumulator, accumulator_next;
  logic       error_flag, error_flag_next;
  value_t     finished_fields [NUM_STORED];

  logic       do_sign, do_digits, do_end;
  logic       ff_we;
  value_t     num_value;
  logic       close_rec, close_ok, close_end;
  value_t     last_value;

  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_byte <= text_byte;
      stage_eof  <= end_of_input;
    end
  end

  assign num_value = negative_flag ? (value_t'(0) - accumulator) : accumulator;

  always_comb begin
    phase_next         = phase;
    skip_left_next     = skip_left;
    field_index_next   = field_index;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    error_flag_next    = error_flag;
    do_sign            = 1'b0;
    do_digits          = 1'b0;
    do_end             = 1'b0;
    ff_we              = 1'b0;
    close_rec          = 1'b0;
    close_ok           = 1'b0;
    close_end          = 1'b0;
    last_value         = accumulator;

    unique case (phase)
      PH_SKIP: begin
        if (stage_eof) begin
          close_rec = 1'b1;
          close_end = 1'b1;
        end else if (skip_left != 8'd0) begin
          skip_left_next = skip_left - 8'd1;
        end else begin
          do_sign = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digits = 1'b1;
      end
      PH_WS: begin
        if (stage_eof || !is_ws(stage_byte)) begin
          do_sign = 1'b1;
        end
      end
      PH_DISCARD: begin
        if (stage_eof || (stage_byte == CHAR_NL)) begin
          close_rec = 1'b1;
          close_ok  = !error_flag;
          close_end = stage_eof;
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase

    if (do_sign) begin
      phase_next = PH_DIGITS;
      if (!stage_eof && (stage_byte == CHAR_MINUS)) begin
        negative_flag_next = 1'b1;
      end else begin
        do_digits = 1'b1;
      end
    end

    if (do_digits) begin
      if (!stage_eof && is_digit(stage_byte)) begin
        accumulator_next = accumulator * value_t'(DEC_BASE)
                         + value_t'(4'(stage_byte - CHAR_ZERO));
      end else begin
        do_end = 1'b1;
      end
    end

    if (do_end) begin
      negative_flag_next = 1'b0;
      if (field_index != 2'(NUM_STORED)) begin
        ff_we = 1'b1;
        if (stage_eof) begin
          close_rec = 1'b1;
          close_end = 1'b1;
        end else if (is_ws(stage_byte)) begin
          field_index_next = field_index + 2'd1;
          accumulator_next = '0;
          phase_next       = PH_WS;
        end else begin
          error_flag_next = 1'b1;
          phase_next      = PH_DISCARD;
        end
      end else begin
        accumulator_next = num_value;
        last_value       = num_value;
        if (stage_eof || (stage_byte == CHAR_NL)) begin
          close_rec = 1'b1;
          close_ok  = 1'b1;
          close_end = stage_eof;
        end else begin
          error_flag_next = 1'b0;
          phase_next      = PH_DISCARD;
        end
      end
    end

    if (close_rec) begin
      phase_next         = PH_SKIP;
      skip_left_next     = skip_count;
      field_index_next   = '0;
      negative_flag_next = 1'b0;
      accumulator_next   = '0;
      error_flag_next    = 1'b0;
    end
  end

  // parser state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count    <= '0;
      phase         <= PH_SKIP;
      skip_left     <= '0;
      field_index   <= '0;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      error_flag    <= 1'b0;
    end else begin
      if (advance) begin
        phase         <= phase_next;
        skip_left     <= skip_left_next;
        field_index   <= field_index_next;
        negative_flag <= negative_flag_next;
        accumulator   <= accumulator_next;
        error_flag    <= error_flag_next;
      end
      if (cfg_valid && cfg_ready) begin
        skip_count <= skip_bytes;
        if (phase == PH_SKIP) begin
          skip_left <= skip_bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ff_we) begin
      finished_fields[field_index] <= num_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && close_rec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && close_rec) begin
      x_low         <= close_ok ? to_out(finished_fields[0]) : '0;
      y_low         <= close_ok ? to_out(finished_fields[1]) : '0;
      x_high        <= close_ok ? to_out(finished_fields[2]) : '0;
      y_high        <= close_ok ? to_out(last_value) : '0;
      record_ok     <= close_ok;
      closed_by_end <= close_end;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_ok |-> x_low == 0 && y_low == 0 && x_high == 0 && y_high == 0)
    else $error("failed record carries non-zero values");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> field_index == 2'd0 && accumulator == '0 && !negative_flag
                         && !error_flag)
    else $error("record start state not clean");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_left <= skip_count)
    else $error("skip counter above configured count");

  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    advance && close_rec |=> out_valid)
    else $error("closed record not presented");

  a_ws_has_field: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WS |-> field_index != 2'd0)
    else $error("separator phase before first number");

endmodule

/* verif/tb_top.sv */
module tb_top
  import fsdrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_ITEMS = 1350;
  localparam int QUIET_TAIL   = 200;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 10;
  localparam int SHOW_LIMIT   = 10;

  localparam logic [7:0] CHAR_VT = 8'h0b;
  localparam logic [7:0] CHAR_FF = 8'h0c;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] x_lo;
    logic signed [OUT_WIDTH-1:0] y_lo;
    logic signed [OUT_WIDTH-1:0] x_hi;
    logic signed [OUT_WIDTH-1:0] y_hi;
    logic                        ok;
    logic                        by_end;
  } record_t;

  class record_predictor;
    logic [7:0]  skip_cfg;
    phase_t      ph;
    logic [7:0]  skip_left;
    int unsigned field_no;
    bit          neg;
    value_t      acc;
    value_t      stored[NUM_STORED];
    bit          bad;
    record_t     expected_records[$];
    int          mismatches;
    int          checked;
    int          good_records;
    int          eof_records;

    function new();
      skip_cfg = '0;
      foreach (stored[i]) stored[i] = '0;
      mismatches = 0;
      checked = 0;
      good_records = 0;
      eof_records = 0;
      start_record();
    endfunction

    function void start_record();
      ph = PH_SKIP;
      skip_left = skip_cfg;
      field_no = 0;
      neg = 1'b0;
      acc = '0;
      bad = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
    endfunction

    function void close_record(bit ok, bit by_end);
      record_t r;
      r.x_lo = ok ? OUT_WIDTH'(signed'(stored[0])) : '0;
      r.y_lo = ok ? OUT_WIDTH'(signed'(stored[1])) : '0;
      r.x_hi = ok ? OUT_WIDTH'(signed'(stored[2])) : '0;
      r.y_hi = ok ? OUT_WIDTH'(signed'(acc)) : '0;
      r.ok = ok;
      r.by_end = by_end;
      expected_records.push_back(r);
      foreach (stored[i]) stored[i] = '0;
      start_record();
    endfunction

    function void end_number(logic [7:0] b, logic eof);
      value_t v;
      v = neg ? value_t'('0 - acc) : acc;
      neg = 1'b0;
      if (field_no < NUM_STORED) begin
        stored[field_no] = v;
        if (eof) begin
          close_record(1'b0, 1'b1);
        end else if (is_blank(b)) begin
          field_no++;
          acc = '0;
          ph = PH_WS;
        end else begin
          bad = 1'b1;
          ph = PH_DISCARD;
        end
        return;
      end
      acc = v;
      if (eof) begin
        close_record(1'b1, 1'b1);
      end else if (b == CHAR_NL) begin
        close_record(1'b1, 1'b0);
      end else begin
        bad = 1'b0;
        ph = PH_DISCARD;
      end
    endfunction

    function void take_digit(logic [7:0] b, logic eof);
      if (!eof && b >= CHAR_ZERO && b <= CHAR_NINE)
        acc = value_t'(acc * DEC_BASE + value_t'(b - CHAR_ZERO));
      else
        end_number(b, eof);
    endfunction

    function void take_sign(logic [7:0] b, logic eof);
      ph = PH_DIGITS;
      if (!eof && b == CHAR_MINUS)
        neg = 1'b1;
      else
        take_digit(b, eof);
    endfunction

    function void note_config(logic [7:0] v);
      skip_cfg = v;
      if (ph == PH_SKIP)
        skip_left = v;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      case (ph)
        PH_SKIP: begin
          if (eof)
            close_record(1'b0, 1'b1);
          else if (skip_left != 0)
            skip_left--;
          else
            take_sign(b, eof);
        end
        PH_DIGITS: take_digit(b, eof);
        PH_WS: begin
          if (eof || !is_blank(b))
            take_sign(b, eof);
        end
        default: begin
          if (eof)
            close_record(!bad, 1'b1);
          else if (b == CHAR_NL)
            close_record(!bad, 1'b0);
        end
      endcase
    endfunction

    function int pending();
      return expected_records.size();
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected record %0d %0d %0d %0d ok=%0b end=%0b", $time,
                   got.x_lo, got.y_lo, got.x_hi, got.y_hi, got.ok, got.by_end);
        return;
      end
      want = expected_records.pop_front();
      checked++;
      if (want.ok)
        good_records++;
      if (want.by_end)
        eof_records++;
      if (got.x_lo !== want.x_lo || got.y_lo !== want.y_lo || got.x_hi !== want.x_hi ||
          got.y_hi !== want.y_hi || got.ok !== want.ok || got.by_end !== want.by_end) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("%0t: record mismatch, expected %0d %0d %0d %0d ok=%0b end=%0b", $time,
                   want.x_lo, want.y_lo, want.x_hi, want.y_hi, want.ok, want.by_end);
          $display("%0t:                     got %0d %0d %0d %0d ok=%0b end=%0b", $time,
                   got.x_lo, got.y_lo, got.x_hi, got.y_hi, got.ok, got.by_end);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] text_byte = '0;
  logic end_of_input = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] skip_bytes = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_WIDTH-1:0] x_low;
  logic signed [OUT_WIDTH-1:0] y_low;
  logic signed [OUT_WIDTH-1:0] x_high;
  logic signed [OUT_WIDTH-1:0] y_high;
  logic record_ok;
  logic closed_by_end;

  record_predictor board;
  logic [7:0] blanks[6] = '{CHAR_SPACE, CHAR_TAB, CHAR_NL, CHAR_VT, CHAR_FF, CHAR_CR};
  logic [7:0] cur_skip = '0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int send_idle_pct = 20;
  int items_sent = 0;
  int filler_items = 0;
  int skip_writes = 0;

  four_signed_decimal_record_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .skip_bytes   (skip_bytes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .x_low        (x_low),
    .y_low        (y_low),
    .x_high       (x_high),
    .y_high       (y_high),
    .record_ok    (record_ok),
    .closed_by_end(closed_by_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    record_t got;
    if (!rst && out_valid && out_ready && board != null) begin
      got.x_lo = x_low;
      got.y_lo = y_low;
      got.x_hi = x_high;
      got.y_hi = y_high;
      got.ok = record_ok;
      got.by_end = closed_by_end;
      board.check_record(got);
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("four_signed_decimal_record_parser test failed");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic eof);
    if (!no_idle && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_input <= eof;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b, eof);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_skip(input logic [7:0] v);
    cfg_valid <= 1'b1;
    skip_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.note_config(v);
    cur_skip = v;
    skip_writes++;
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_NL);
    return b;
  endfunction

  function automatic logic [7:0] bad_terminator();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR], [CHAR_ZERO:CHAR_NINE]});
    return b;
  endfunction

  task automatic send_filler(input int n);
    repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
    filler_items += n;
  endtask

  task automatic send_number();
    int r;
    int n;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0)
      send_item(CHAR_MINUS, 1'b0);
    n = (r == 0) ? 0 : (r < 4) ? $urandom_range(10, 14) : $urandom_range(1, 6);
    repeat (n) send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(1, 3)) send_item(blanks[$urandom_range(0, 5)], 1'b0);
  endtask

  task automatic good_record();
    int k;
    send_filler(cur_skip);
    for (k = 0; k < 4; k++) begin
      send_number();
      if (k < 3)
        send_blanks();
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      send_item(CHAR_NL, 1'b0);
    end else if (k < 9) begin
      repeat ($urandom_range(1, 5)) send_item(junk_byte(), 1'b0);
      send_item(CHAR_NL, 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic broken_record();
    int k;
    int cut;
    send_filler(cur_skip);
    cut = $urandom_range(0, 2);
    for (k = 0; k <= cut; k++) begin
      send_number();
      if (k < cut)
        send_blanks();
    end
    case ($urandom_range(0, 2))
      0: begin
        send_item(bad_terminator(), 1'b0);
        repeat ($urandom_range(0, 4)) send_item(junk_byte(), 1'b0);
        send_item(CHAR_NL, 1'b0);
      end
      1: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: repeat ($urandom_range(1, 20)) send_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  initial begin
    int p;
    int nrec;
    int hold_phase;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_skip(8'd0);
    // negatives, lone minus as fourth number, newline between numbers
    send_text("-1 2\n\t3 -\n");
    send_text("1x\n");
    send_text("5 ");
    send_item(8'h00, 1'b1);
    // end of input in the blanks before the fourth number
    send_text("1 2 3 ");
    send_item(8'hff, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(CHAR_NL, 1'b0);
    settle();
    write_skip(8'd3);
    send_item(8'h00, 1'b0);
    send_item(CHAR_NL, 1'b0);
    settle();
    // reload of the skip count part way through the skip
    write_skip(8'd1);
    send_item("a", 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CHAR_ZERO, 1'b1);

    p = 0;
    hold_phase = 2;
    while (items_sent < TARGET_ITEMS) begin
      settle();
      if (items_sent > TARGET_ITEMS - QUIET_TAIL)
        no_idle = 1'b1;
      write_skip(p == 1 ? 8'd255 : p == 3 ? 8'd0 : 8'($urandom_range(0, 4)));
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (p == hold_phase)
        hold_req = 1'b1;
      nrec = (cur_skip == 8'd255) ? 2 : $urandom_range(5, 12);
      repeat (nrec) begin
        if ($urandom_range(0, 4) == 0)
          broken_record();
        else
          good_record();
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
      p++;
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d of them skipped filler) over %0d skip settings",
             items_sent, filler_items, skip_writes);
    $display("checked %0d records: %0d well formed, %0d closed by end of input",
             board.checked, board.good_records, board.eof_records);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("four_signed_decimal_record_parser test passed");
    end else begin
      $display("%0d mismatches, %0d records still expected", board.mismatches,
               board.pending());
      $display("four_signed_decimal_record_parser test failed");
    end
    $finish;
  end

endmodule
